### hw/rtl/fwimg_pkg.sv
package fwimg_pkg;

    localparam logic [31:0] MAX_IMAGE_BYTES = 32'd1048576;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [15:0] CRC_MSB         = 16'h8000;
    localparam logic [15:0] CRC_ZERO        = 16'h0000;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    // Command opcodes
    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_META     = 3'd1;
    localparam logic [2:0] OP_PREPARE  = 3'd2;
    localparam logic [2:0] OP_CHUNK    = 3'd3;
    localparam logic [2:0] OP_FINALIZE = 3'd4;

    // Status codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_WRONG_STAGE   = 4'd1;
    localparam logic [3:0] ST_NOT_PREPARED  = 4'd2;
    localparam logic [3:0] ST_BAD_OFFSET    = 4'd3;
    localparam logic [3:0] ST_SIZE_ZERO     = 4'd4;
    localparam logic [3:0] ST_SIZE_BIG      = 4'd5;
    localparam logic [3:0] ST_CRC_ZERO      = 4'd6;
    localparam logic [3:0] ST_OVERFLOW      = 4'd7;
    localparam logic [3:0] ST_SIZE_MISMATCH = 4'd8;
    localparam logic [3:0] ST_CRC_MISMATCH  = 4'd9;

    // Stage codes as reported on the result channel
    localparam logic [2:0] STG_IDLE   = 3'd0;
    localparam logic [2:0] STG_META   = 3'd1;
    localparam logic [2:0] STG_RECV   = 3'd2;
    localparam logic [2:0] STG_VERIFY = 3'd3;
    localparam logic [2:0] STG_BOOT   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_META   = 5'b00010,
        S_RECV   = 5'b00100,
        S_VERIFY = 5'b01000,
        S_BOOT   = 5'b10000
    } stage_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] image_size;
        logic [15:0] image_crc;
        logic [7:0]  target_bank;
        logic [7:0]  chunk_byte;
        logic [31:0] chunk_offset;
        logic        first_of_chunk;
        logic        last_of_chunk;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  stage_now;
        logic [15:0] crc_now;
        logic [31:0] bytes_so_far;
        logic        crc_ok;
        logic        storage_ready;
        logic [7:0]  bank_now;
    } result_t;

    // Held command between the input register and the core
    typedef struct packed {
        logic  valid;
        item_t item;
    } slot_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic    load;
        result_t result;
    } load_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((r & CRC_MSB) != CRC_ZERO)
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [2:0] stage_code(input stage_t s);
        logic [2:0] c;
        case (s)
            S_IDLE:   c = STG_IDLE;
            S_META:   c = STG_META;
            S_RECV:   c = STG_RECV;
            S_VERIFY: c = STG_VERIFY;
            S_BOOT:   c = STG_BOOT;
            default:  c = STG_IDLE;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/fwimg_in_if.sv
interface fwimg_in_if
    import fwimg_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/fwimg_out_if.sv
interface fwimg_out_if
    import fwimg_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/fwimg_in_stage.sv
module fwimg_in_stage
    import fwimg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fwimg_in_if.sink   cmd,
    input  logic       take,
    output slot_t      slot
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Refill in the same cycle the core drains the held command
    assign cmd.ready = !valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= cmd.item;
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

### hw/rtl/fwimg_core.sv
module fwimg_core
    import fwimg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  slot_t slot,
    input  logic  room,
    output logic  take,
    output load_t load
);

    stage_t      stage_reg,         stage_next;
    logic        meta_seen_reg,     meta_seen_next;
    logic        prepared_reg,      prepared_next;
    logic [31:0] exp_len_reg,       exp_len_next;
    logic [15:0] exp_crc_reg,       exp_crc_next;
    logic [7:0]  bank_reg,          bank_next;
    logic [15:0] crc_reg,           crc_next;
    logic [31:0] count_reg,         count_next;
    logic        matched_reg,       matched_next;
    logic [3:0]  verdict_reg,       verdict_next;

    logic [3:0]  status;
    logic [3:0]  verdict;
    logic [31:0] count_inc;
    item_t       it;

    assign it   = slot.item;
    assign take = slot.valid && room;

    always_comb
    begin
        stage_next     = stage_reg;
        meta_seen_next = meta_seen_reg;
        prepared_next  = prepared_reg;
        exp_len_next   = exp_len_reg;
        exp_crc_next   = exp_crc_reg;
        bank_next      = bank_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        matched_next   = matched_reg;
        verdict_next   = verdict_reg;
        status         = ST_OK;
        verdict        = verdict_reg;
        count_inc      = (count_reg != COUNT_MAX) ? count_reg + 32'd1 : count_reg;

        case (it.op)
            OP_CLEAR:
            begin
                stage_next     = S_IDLE;
                meta_seen_next = 1'b0;
                prepared_next  = 1'b0;
                exp_len_next   = '0;
                exp_crc_next   = '0;
                bank_next      = '0;
                crc_next       = '0;
                count_next     = '0;
                matched_next   = 1'b0;
                verdict_next   = ST_OK;
            end
            OP_META:
            begin
                if (it.image_size == '0)
                    status = ST_SIZE_ZERO;
                else if (it.image_size > MAX_IMAGE_BYTES)
                    status = ST_SIZE_BIG;
                else if (it.image_crc == CRC_ZERO)
                    status = ST_CRC_ZERO;
                else
                begin
                    exp_len_next   = it.image_size;
                    exp_crc_next   = it.image_crc;
                    bank_next      = it.target_bank;
                    stage_next     = S_META;
                    meta_seen_next = 1'b1;
                    crc_next       = CRC_SEED;
                end
            end
            OP_PREPARE:
            begin
                if (stage_reg != S_META)
                    status = ST_WRONG_STAGE;
                else
                begin
                    prepared_next = 1'b1;
                    stage_next    = S_RECV;
                end
            end
            OP_CHUNK:
            begin
                // Re-judge on a first byte, or while the chunk is still clean
                if (it.first_of_chunk || verdict_reg == ST_OK)
                begin
                    if (stage_reg != S_RECV)
                        verdict = ST_WRONG_STAGE;
                    else if (!prepared_reg)
                        verdict = ST_NOT_PREPARED;
                    else if (it.first_of_chunk && it.chunk_offset != count_reg)
                        verdict = ST_BAD_OFFSET;
                    else
                        verdict = ST_OK;
                end
                verdict_next = verdict;
                if (verdict != ST_OK)
                    status = verdict;
                else
                begin
                    crc_next   = crc_byte(crc_reg, it.chunk_byte);
                    count_next = count_inc;
                    if (it.last_of_chunk && count_inc > exp_len_reg)
                        status = ST_OVERFLOW;
                end
            end
            OP_FINALIZE:
            begin
                if (count_reg != exp_len_reg)
                    status = ST_SIZE_MISMATCH;
                else if (crc_reg != exp_crc_reg)
                begin
                    stage_next   = S_VERIFY;
                    matched_next = 1'b0;
                    status       = ST_CRC_MISMATCH;
                end
                else
                begin
                    stage_next   = S_BOOT;
                    matched_next = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= S_IDLE;
            meta_seen_reg <= 1'b0;
            prepared_reg  <= 1'b0;
            exp_len_reg   <= '0;
            exp_crc_reg   <= '0;
            bank_reg      <= '0;
            crc_reg       <= '0;
            count_reg     <= '0;
            matched_reg   <= 1'b0;
            verdict_reg   <= ST_OK;
        end
        else if (take)
        begin
            stage_reg     <= stage_next;
            meta_seen_reg <= meta_seen_next;
            prepared_reg  <= prepared_next;
            exp_len_reg   <= exp_len_next;
            exp_crc_reg   <= exp_crc_next;
            bank_reg      <= bank_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            matched_reg   <= matched_next;
            verdict_reg   <= verdict_next;
        end
    end

    assign load.load                 = take;
    assign load.result.status        = status;
    assign load.result.stage_now     = stage_code(stage_next);
    assign load.result.crc_now       = crc_next;
    assign load.result.bytes_so_far  = count_next;
    assign load.result.crc_ok        = matched_next;
    assign load.result.storage_ready = prepared_next;
    assign load.result.bank_now      = bank_next;

    // Receiving implies storage was prepared
    a_recv_prepared: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == S_RECV) |-> prepared_reg)
        else $error("receiving stage without prepared storage");

    // Ready to boot only after a matching CRC
    a_boot_matched: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == S_BOOT) |-> matched_reg)
        else $error("boot stage without CRC match");

    // Byte count never runs backward except on clear
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (take && it.op != OP_CLEAR) |=> (count_reg >= $past(count_reg)))
        else $error("received count decreased");

    // Clear returns the context to idle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && it.op == OP_CLEAR) |=>
            (stage_reg == S_IDLE && count_reg == '0 && !prepared_reg))
        else $error("clear did not reset the context");

endmodule

### hw/rtl/fwimg_out_stage.sv
module fwimg_out_stage
    import fwimg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  load_t       load,
    output logic        room,
    fwimg_out_if.source rsp
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Accept a new result when empty or when the current one leaves now
    assign room = !valid_reg || rsp.ready;

    always_comb
    begin
        if (load.load)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
            result_reg <= load.result;
    end

    assign rsp.valid = valid_reg;
    assign rsp.item  = result_reg;

endmodule

### hw/rtl/firmware_image_receiver_top.sv
// Firmware image receiver.
// cmd: command transactions (clear, metadata, prepare, chunk byte, finalize),
//   one image byte per chunk-byte transaction, with chunk first/last marks.
// rsp: one result transaction per command: status, stage, running CRC-16,
//   received byte count, CRC match flag, storage-prepared flag and bank.
// Pipeline: one register holds the command, one holds the result, and the
//   byte-wide CRC-16 update sits between them.
// Throughput: one transaction per cycle sustained while rsp.ready stays high;
//   the single input register feeds the single result register.
// Reset: rst_n low clears the context to idle (no metadata, storage not
//   prepared, CRC and count zero) and empties both registers.
// Stall: while rsp.ready is low the result is held; one more command is
//   taken into the input register, then cmd.ready drops until rsp drains.
module firmware_image_receiver_top
    import fwimg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fwimg_in_if.sink    cmd,
    fwimg_out_if.source rsp
);

    slot_t slot;
    load_t load;
    logic  take;
    logic  room;

    // Hold the incoming command
    fwimg_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .slot  (slot)
    );

    // Decode the command, advance the context, build the result
    fwimg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot),
        .room  (room),
        .take  (take),
        .load  (load)
    );

    // Hold the result until the sink takes it
    fwimg_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .room  (room),
        .rsp   (rsp)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the firmware image receiver. Commands go in on cmd,
// one result per command comes back on rsp, and every result is compared field
// by field with the oldest entry of an in-order queue of predicted results.
module tb;
    import fwimg_pkg::*;

    // Give up after this many cycles in which neither channel moves a transaction.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_COMMANDS = 1500;

    logic clk;
    logic rst_n;

    fwimg_in_if  cmd_if ();
    fwimg_out_if rsp_if ();

    firmware_image_receiver_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Context tracked by the predictor, updated once per accepted command.
    logic [2:0]  img_stage;
    logic        have_meta;
    logic        flash_ready;
    logic [31:0] want_len;
    logic [15:0] want_crc;
    logic [7:0]  sel_bank;
    logic [15:0] run_crc;
    logic [31:0] byte_count;
    logic        crc_matched;
    logic [3:0]  chunk_status;

    result_t     predicted_results[$];
    result_t     oldest_result;

    int          mismatches;
    int          commands_sent;
    int          results_checked;
    int          images_booted;
    int          quiet_cycles;
    int unsigned hold_cycles;
    bit          idle_on;
    bit          status_seen[16];

    // Free-running 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Bit-serial CRC-16 (poly 0x1021, MSB first): feed one data bit per shift.
    function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void clear_context();
        img_stage    = STG_IDLE;
        have_meta    = 1'b0;
        flash_ready  = 1'b0;
        want_len     = '0;
        want_crc     = CRC_ZERO;
        sel_bank     = '0;
        run_crc      = CRC_ZERO;
        byte_count   = '0;
        crc_matched  = 1'b0;
        chunk_status = ST_OK;
    endfunction

    // Apply one command to the tracked context and return the result it causes.
    function automatic result_t next_receiver_result(input item_t it);
        result_t    r;
        logic [3:0] st;
        st = ST_OK;
        case (it.op)
            OP_CLEAR:
                clear_context();
            OP_META:
            begin
                if (it.image_size == '0)
                    st = ST_SIZE_ZERO;
                else if (it.image_size > MAX_IMAGE_BYTES)
                    st = ST_SIZE_BIG;
                else if (it.image_crc == CRC_ZERO)
                    st = ST_CRC_ZERO;
                else
                begin
                    // Keep the byte count, the prepared flag and the match flag.
                    want_len  = it.image_size;
                    want_crc  = it.image_crc;
                    sel_bank  = it.target_bank;
                    img_stage = STG_META;
                    have_meta = 1'b1;
                    run_crc   = CRC_SEED;
                end
            end
            OP_PREPARE:
            begin
                if (img_stage != STG_META)
                    st = ST_WRONG_STAGE;
                else
                begin
                    flash_ready = 1'b1;
                    img_stage   = STG_RECV;
                end
            end
            OP_CHUNK:
            begin
                // Judge a chunk on its first byte; later bytes inherit a failed verdict, but a
                // clean chunk is judged again on each byte and so sees a stage change made in between.
                if (it.first_of_chunk || chunk_status == ST_OK)
                begin
                    if (img_stage != STG_RECV)
                        chunk_status = ST_WRONG_STAGE;
                    else if (!flash_ready)
                        chunk_status = ST_NOT_PREPARED;
                    else if (it.first_of_chunk && it.chunk_offset != byte_count)
                        chunk_status = ST_BAD_OFFSET;
                    else
                        chunk_status = ST_OK;
                end
                if (chunk_status != ST_OK)
                    st = chunk_status;
                else
                begin
                    run_crc = crc16_feed(run_crc, it.chunk_byte);
                    if (byte_count != COUNT_MAX)
                        byte_count = byte_count + 32'd1;
                    if (it.last_of_chunk && byte_count > want_len)
                        st = ST_OVERFLOW;
                end
            end
            OP_FINALIZE:
            begin
                if (byte_count != want_len)
                    st = ST_SIZE_MISMATCH;
                else
                begin
                    img_stage   = STG_VERIFY;
                    crc_matched = (run_crc == want_crc);
                    if (!crc_matched)
                        st = ST_CRC_MISMATCH;
                    else
                    begin
                        img_stage = STG_BOOT;
                        images_booted++;
                    end
                end
            end
            default:
                ;
        endcase
        r.status        = st;
        r.stage_now     = img_stage;
        r.crc_now       = run_crc;
        r.bytes_so_far  = byte_count;
        r.crc_ok        = crc_matched;
        r.storage_ready = flash_ready;
        r.bank_now      = sel_bank;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------

    // Fill every field at random so that fields a command ignores still toggle.
    function automatic item_t any_item();
        item_t it;
        it.op             = 3'($urandom_range(7));
        it.image_size     = $urandom;
        it.image_crc      = 16'($urandom);
        it.target_bank    = 8'($urandom);
        it.chunk_byte     = 8'($urandom);
        it.chunk_offset   = $urandom;
        it.first_of_chunk = 1'($urandom);
        it.last_of_chunk  = 1'($urandom);
        return it;
    endfunction

    function automatic item_t op_item(input logic [2:0] op);
        item_t it;
        it    = any_item();
        it.op = op;
        return it;
    endfunction

    function automatic item_t meta_item(input logic [31:0] size, input logic [15:0] crc,
                                        input logic [7:0] bank);
        item_t it;
        it             = op_item(OP_META);
        it.image_size  = size;
        it.image_crc   = crc;
        it.target_bank = bank;
        return it;
    endfunction

    function automatic item_t chunk_item(input logic [7:0] b, input logic [31:0] offset,
                                         input logic first, input logic last);
        item_t it;
        it                = op_item(OP_CHUNK);
        it.chunk_byte     = b;
        it.chunk_offset   = offset;
        it.first_of_chunk = first;
        it.last_of_chunk  = last;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver, checker
    // ------------------------------------------------------------------

    // Offer one command from a falling edge, hold it until the handshake, then
    // drop valid and queue its prediction at the following falling edge. The
    // queue therefore never changes at a rising edge, where results are popped.
    task automatic send_command(input item_t it);
        result_t want;
        while (idle_on && $urandom_range(99) < 17)
        begin
            cmd_if.valid = 1'b0;
            @(negedge clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.item  = it;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        want = next_receiver_result(it);
        commands_sent++;
        @(negedge clk);
        cmd_if.valid = 1'b0;
        predicted_results.push_back(want);
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_all_results();
        while (predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // Change knobs that the receiver reads at the falling edge from the rising
    // edge, then return to the falling edge where the sender works.
    task automatic set_idling(input bit on, input int unsigned hold);
        @(posedge clk);
        idle_on     = on;
        hold_cycles = hold;
        @(negedge clk);
    endtask

    // Receiver: honor a requested hold-off first, else stall at random while idling is on.
    always @(negedge clk)
    begin
        if (hold_cycles != 0)
        begin
            rsp_if.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end
        else
            rsp_if.ready = idle_on ? ($urandom_range(99) >= 17) : 1'b1;
    end

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: ERROR %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Checker: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: ERROR result with nothing pending, expected none actual %h",
                         $time, rsp_if.item);
                mismatches++;
            end
            else
            begin
                oldest_result = predicted_results.pop_front();
                report_field("status",        32'(oldest_result.status),
                             32'(rsp_if.item.status));
                report_field("stage_now",     32'(oldest_result.stage_now),
                             32'(rsp_if.item.stage_now));
                report_field("crc_now",       32'(oldest_result.crc_now),
                             32'(rsp_if.item.crc_now));
                report_field("bytes_so_far",  oldest_result.bytes_so_far,
                             rsp_if.item.bytes_so_far);
                report_field("crc_ok",        32'(oldest_result.crc_ok),
                             32'(rsp_if.item.crc_ok));
                report_field("storage_ready", 32'(oldest_result.storage_ready),
                             32'(rsp_if.item.storage_ready));
                report_field("bank_now",      32'(oldest_result.bank_now),
                             32'(rsp_if.item.bank_now));
                status_seen[oldest_result.status] = 1'b1;
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d results still pending", $time,
                         predicted_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each command but metadata straight out of reset: prepare and chunks see the wrong
    // stage, finalize matches a zero count against a zero size and a zero CRC
    // against a zero CRC, and spare opcodes 5 and 7 are ignored.
    task automatic test_commands_from_idle();
        send_command(op_item(OP_PREPARE));
        send_command(chunk_item(8'h00, 32'h0, 1'b1, 1'b0));
        send_command(chunk_item(8'hFF, 32'h0, 1'b0, 1'b1));
        send_command(op_item(OP_FINALIZE));
        send_command(op_item(3'd5));
        send_command(op_item(3'd7));
        send_command(op_item(OP_CLEAR));
    endtask

    // Metadata rejections in their priority order, then the largest and the smallest legal size.
    task automatic test_metadata_limits();
        send_command(meta_item(32'h0, CRC_ZERO, 8'h00));
        send_command(meta_item(COUNT_MAX, 16'hFFFF, 8'hFF));
        send_command(meta_item(MAX_IMAGE_BYTES + 32'd1, 16'h1234, 8'h5A));
        send_command(meta_item(32'd1, CRC_ZERO, 8'h11));
        send_command(meta_item(MAX_IMAGE_BYTES, 16'hFFFF, 8'hFF));
        send_command(meta_item(32'd1, 16'h0001, 8'h00));
    endtask

    // A three-byte image with chunk faults, overflow, both finalize failures and a final boot.
    task automatic test_image_and_faults();
        logic [15:0] good_crc;
        good_crc = crc16_feed(crc16_feed(crc16_feed(CRC_SEED, 8'h00), 8'hFF), 8'h5A);
        send_command(op_item(OP_CLEAR));
        send_command(meta_item(32'd3, good_crc, 8'hA5));
        send_command(op_item(OP_PREPARE));
        send_command(op_item(OP_PREPARE));                        // second prepare: wrong stage
        send_command(chunk_item(8'h00, 32'h0, 1'b1, 1'b0));
        send_command(chunk_item(8'hFF, $urandom, 1'b0, 1'b1));
        send_command(chunk_item(8'h11, COUNT_MAX, 1'b1, 1'b0));   // bad offset
        send_command(chunk_item(8'h22, $urandom, 1'b0, 1'b1));   // dropped with its chunk
        send_command(chunk_item(8'h5A, 32'd2, 1'b1, 1'b1));
        // A byte with no first mark after a finished chunk extends it: overflow.
        send_command(chunk_item(8'h33, $urandom, 1'b0, 1'b1));
        send_command(op_item(OP_FINALIZE));                       // size mismatch
        // New metadata reseeds the CRC but keeps the count of four bytes.
        send_command(meta_item(32'd4, 16'h1234, 8'h00));
        send_command(op_item(OP_FINALIZE));                       // CRC mismatch
        send_command(meta_item(32'd4, CRC_SEED, 8'hFF));
        send_command(op_item(OP_FINALIZE));                       // ready to boot
    endtask

    // One image session with random content: mostly well formed, sometimes with
    // a wrong expected CRC, a skipped prepare, a lost chunk, a wrong offset, a stray
    // command or a trailing byte.
    task automatic run_image_session();
        logic [7:0]  image[$];
        logic [15:0] crc;
        logic [31:0] offset;
        int          n;
        int          pos;
        int          len;
        int          fault;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        crc = CRC_SEED;
        for (int i = 0; i < n; i++)
        begin
            image.push_back(8'($urandom));
            crc = crc16_feed(crc, image[i]);
        end
        if ($urandom_range(1))
            send_command(op_item(OP_CLEAR));
        send_command(meta_item(32'(n), ($urandom_range(3) == 0) ? 16'($urandom) : crc,
                               8'($urandom)));
        if ($urandom_range(19) != 0)
            send_command(op_item(OP_PREPARE));
        pos = 0;
        while (pos < n)
        begin
            len = $urandom_range(1, 8);
            if (pos + len > n)
                len = n - pos;
            fault  = $urandom_range(29);
            offset = byte_count;
            if (fault == 1)
                offset = offset + 32'($urandom_range(1, 3));
            else if (fault == 2)
                send_command(any_item());
            if (fault != 0)
            begin
                for (int i = 0; i < len; i++)
                    send_command(chunk_item(image[pos + i], (i == 0) ? offset : $urandom,
                                            i == 0, i == len - 1));
            end
            pos = pos + len;
        end
        if ($urandom_range(9) == 0)
            send_command(chunk_item(8'($urandom), $urandom, 1'b0, 1'b1));
        send_command(op_item(OP_FINALIZE));
    endtask

    // Random sessions and noise; the first part runs with no idling at all.
    task automatic test_random_images();
        int start;
        start = commands_sent;
        set_idling(1'b0, 0);
        while (commands_sent < start + RANDOM_COMMANDS)
        begin
            if (commands_sent > start + 300 && !idle_on)
                set_idling(1'b1, 0);
            if ($urandom_range(9) == 0)
                send_command(any_item());
            else
                run_image_session();
        end
    endtask

    // Hold the result side off for a long stretch while commands keep coming,
    // so the block fills and stalls its input.
    task automatic test_result_backpressure();
        set_idling(1'b1, 150);
        send_command(op_item(OP_CLEAR));
        send_command(meta_item(32'd16, 16'hBEEF, 8'h3C));
        send_command(op_item(OP_PREPARE));
        for (int i = 0; i < 16; i++)
            send_command(chunk_item(8'($urandom), 32'(i), 1'b1, 1'b1));
        send_command(op_item(OP_FINALIZE));
        wait_all_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.item   = '0;
        rsp_if.ready  = 1'b0;
        idle_on       = 1'b1;
        hold_cycles   = 0;
        mismatches    = 0;
        commands_sent = 0;
        results_checked = 0;
        images_booted = 0;
        quiet_cycles  = 0;
        clear_context();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_commands_from_idle();
        test_metadata_limits();
        test_image_and_faults();
        wait_all_results();
        test_result_backpressure();
        test_random_images();
        test_result_backpressure();

        // Drain, then let the pipeline settle.
        wait_all_results();
        repeat (8) @(negedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0t: ERROR %0d results never arrived", $time, predicted_results.size());
            mismatches++;
        end

        begin : summary
            int codes;
            codes = 0;
            foreach (status_seen[k])
                codes += int'(status_seen[k]);
            $display("Checked %0d results for %0d commands; %0d status codes seen.",
                     results_checked, commands_sent, codes);
            $display("%0d images reached ready to boot, with stalls on both channels.",
                     images_booted);
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fwimg_pkg.sv
hw/rtl/fwimg_in_if.sv
hw/rtl/fwimg_out_if.sv
hw/rtl/fwimg_in_stage.sv
hw/rtl/fwimg_core.sv
hw/rtl/fwimg_out_stage.sv
hw/rtl/firmware_image_receiver_top.sv
tb/tb.sv
